@@ rtl/lcw_pkg.sv @@
// Load-cell weigher package: request/result types, register map and constants.
// No dependencies; used by load_cell_weigher_core.
package lcw_pkg;

  localparam int SAMPLE_W       = 24;
  localparam int MAX_WINDOW_DEF = 32;
  localparam int DIVISOR_W      = 16;
  localparam int GRAMS_W        = 16;
  localparam int PROD_W         = 35;

  localparam logic [SAMPLE_W-1:0] SAT_CODE     = 24'h800000;
  localparam logic [GRAMS_W-1:0]  MAX_GRAMS    = 16'd60000;
  localparam logic [GRAMS_W-1:0]  GRAMS_PER_KG = 16'd1000;

  localparam logic [5:0]  MEASURE_WINDOW_RST = 6'd16;
  localparam logic [5:0]  TARE_WINDOW_RST    = 6'd32;
  localparam logic [2:0]  TARE_SETTLE_RST    = 3'd4;
  localparam logic [15:0] CAL_FACTOR_RST     = 16'd1000;
  localparam logic [5:0]  TARGET_KG_RST      = 6'd50;

  typedef enum logic [2:0] {
    REG_MEASURE_WINDOW = 3'd0,
    REG_TARE_WINDOW    = 3'd1,
    REG_TARE_SETTLE    = 3'd2,
    REG_CAL_FACTOR     = 3'd3,
    REG_TARGET_KG      = 3'd4
  } cfg_reg_t;

  localparam logic KIND_WEIGHT = 1'b0;
  localparam logic KIND_TARE   = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       timed_out;
  } req_t;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] avg_raw;
    logic [GRAMS_W-1:0]         weight_grams;
    logic                       target_reached;
    logic                       no_valid;
  } rsp_t;

endpackage

@@ rtl/load_cell_weigher_core.sv @@
// Load-cell weigher top level: window averaging, tare store and gram scaling.
// Depends on lcw_pkg; contains the sequencer and one shared restoring divider.
//
// Samples arrive as requests tagged measurement or tare; timed-out samples and
// the saturation code are counted but not summed. A request that does not
// close a window is accepted without a stall. A request that closes a
// window holds req_stall high while the single shared restoring divider
// (one quotient bit per cycle, DW = 35 + clog2(MAX_WINDOW+1) bits, 41 at the
// default) first forms the signed average and, for a measurement window,
// then divides the net count times 1000 by cal_factor; the stall lasts until
// the result has entered the output register. A result waiting in the output
// register does not block the next request unless that request closes
// another window.
module load_cell_weigher_core
  import lcw_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW     = $clog2(MAX_WINDOW + 1);
  localparam int AW     = SAMPLE_W + CW;
  localparam int DW     = AW + 11;
  localparam int VW     = DIVISOR_W;
  localparam int LW     = CW + 6;
  localparam int STEP_W = $clog2(DW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_AVG,
    S_SIGN,
    S_SCALE,
    S_DIV_G,
    S_FINISH
  } state_t;

  state_t state;

  logic [5:0]  measure_window;
  logic [5:0]  tare_window;
  logic [2:0]  tare_settle;
  logic [15:0] cal_factor;
  logic [5:0]  target_kg;

  logic signed [AW-1:0]       accumulator;
  logic [CW-1:0]              valid_count;
  logic [CW-1:0]              sample_count;
  logic [2:0]                 settle_left;
  logic                       window_kind;
  logic signed [SAMPLE_W-1:0] tare_offset;

  logic [DW-1:0]              quo;
  logic [VW-1:0]              rem;
  logic [VW-1:0]              dvs;
  logic [STEP_W-1:0]          step;
  logic                       neg;
  logic                       none;
  logic signed [SAMPLE_W-1:0] avg;

  // Request path
  logic                       req_acc;
  logic                       restart;
  logic signed [AW-1:0]       acc_b;
  logic [CW-1:0]              vc_b;
  logic [CW-1:0]              sc_b;
  logic [2:0]                 settle_b;
  logic                       sample_ok;
  logic signed [AW-1:0]       acc_n;
  logic [CW-1:0]              vc_n;
  logic [CW-1:0]              sc_n;
  logic [5:0]                 win_reg;
  logic [LW-1:0]              win_e;
  logic [LW-1:0]              len;
  logic                       win_done;
  logic [AW-1:0]              acc_mag;
  logic [2:0]                 settle_reload;

  // Divider step
  logic [VW:0]                trial;
  logic [VW+1:0]              diff;

  // Post-processing
  logic [SAMPLE_W-1:0]        q_lo;
  logic signed [SAMPLE_W-1:0] avg_next;
  logic signed [SAMPLE_W:0]   net;
  logic [SAMPLE_W-1:0]        net_pos;
  logic [PROD_W-1:0]          prod;
  logic [VW-1:0]              cal_eff;
  logic [GRAMS_W-1:0]         grams;
  logic [GRAMS_W-1:0]         target_g;
  logic                       out_free;

  logic                       cfg_wr;
  cfg_reg_t                   cfg_idx;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign cfg_idx   = cfg_reg_t'(paddr[4:2]);
  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    unique case (cfg_idx)
      REG_MEASURE_WINDOW: prdata = {26'd0, measure_window};
      REG_TARE_WINDOW:    prdata = {26'd0, tare_window};
      REG_TARE_SETTLE:    prdata = {29'd0, tare_settle};
      REG_CAL_FACTOR:     prdata = {16'd0, cal_factor};
      REG_TARGET_KG:      prdata = {26'd0, target_kg};
      default:            prdata = 32'd0;
    endcase
  end

  always_comb begin
    restart       = (req.req_type != window_kind);
    acc_b         = restart ? '0 : accumulator;
    vc_b          = restart ? '0 : valid_count;
    sc_b          = restart ? '0 : sample_count;
    settle_reload = (req.req_type == KIND_TARE) ? tare_settle : 3'd0;
    settle_b      = restart ? settle_reload : settle_left;
    sample_ok     = !req.timed_out && (req.sample != SAT_CODE);
    acc_n         = sample_ok ? acc_b + {{(AW-SAMPLE_W){req.sample[SAMPLE_W-1]}}, req.sample}
                              : acc_b;
    vc_n          = sample_ok ? vc_b + 1'b1 : vc_b;
    sc_n          = sc_b + 1'b1;
    win_reg       = (req.req_type == KIND_TARE) ? tare_window : measure_window;
    win_e         = {{CW{1'b0}}, win_reg};
    if (win_reg == 6'd0) begin
      len = LW'(1);
    end else if (win_e > LW'(MAX_WINDOW)) begin
      len = LW'(MAX_WINDOW);
    end else begin
      len = win_e;
    end
    win_done = ({6'd0, sc_n} >= len);
    acc_mag  = acc_n[AW-1] ? AW'(-acc_n) : AW'(acc_n);
  end

  always_comb begin
    trial = {rem, quo[DW-1]};
    diff  = {1'b0, trial} - {2'b00, dvs};
  end

  always_comb begin
    q_lo     = quo[SAMPLE_W-1:0];
    avg_next = none ? '0 : (neg ? SAMPLE_W'(-q_lo) : q_lo);
    net      = {avg[SAMPLE_W-1], avg} - {tare_offset[SAMPLE_W-1], tare_offset};
    net_pos  = net[SAMPLE_W] ? '0 : net[SAMPLE_W-1:0];
    prod     = {{(PROD_W-SAMPLE_W){1'b0}}, net_pos} * PROD_W'(GRAMS_PER_KG);
    cal_eff  = (cal_factor == 16'd0) ? VW'(1) : cal_factor;
    grams    = (quo > DW'(MAX_GRAMS)) ? MAX_GRAMS : quo[GRAMS_W-1:0];
    target_g = GRAMS_W'({10'd0, target_kg} * GRAMS_PER_KG);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      measure_window <= MEASURE_WINDOW_RST;
      tare_window    <= TARE_WINDOW_RST;
      tare_settle    <= TARE_SETTLE_RST;
      cal_factor     <= CAL_FACTOR_RST;
      target_kg      <= TARGET_KG_RST;
      accumulator    <= '0;
      valid_count    <= '0;
      sample_count   <= '0;
      settle_left    <= '0;
      window_kind    <= KIND_WEIGHT;
      tare_offset    <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_MEASURE_WINDOW: measure_window <= pwdata[5:0];
          REG_TARE_WINDOW:    tare_window    <= pwdata[5:0];
          REG_TARE_SETTLE:    tare_settle    <= pwdata[2:0];
          REG_CAL_FACTOR:     cal_factor     <= pwdata[15:0];
          REG_TARGET_KG:      target_kg      <= pwdata[5:0];
          default: ;
        endcase
      end

      if (rsp_valid && !rsp_stall && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            window_kind <= req.req_type;
            if (settle_b != 3'd0) begin
              settle_left  <= settle_b - 3'd1;
              accumulator  <= acc_b;
              valid_count  <= vc_b;
              sample_count <= sc_b;
            end else if (win_done) begin
              accumulator  <= '0;
              valid_count  <= '0;
              sample_count <= '0;
              settle_left  <= settle_reload;
              quo          <= {{(DW-AW){1'b0}}, acc_mag};
              rem          <= '0;
              dvs          <= {{(VW-CW){1'b0}}, vc_n};
              neg          <= acc_n[AW-1];
              none         <= (vc_n == '0);
              step         <= STEP_W'(DW - 1);
              state        <= S_DIV_AVG;
            end else begin
              settle_left  <= 3'd0;
              accumulator  <= acc_n;
              valid_count  <= vc_n;
              sample_count <= sc_n;
            end
          end
        end
        S_DIV_AVG, S_DIV_G: begin
          if (!diff[VW+1]) begin
            rem <= diff[VW-1:0];
            quo <= {quo[DW-2:0], 1'b1};
          end else begin
            rem <= trial[VW-1:0];
            quo <= {quo[DW-2:0], 1'b0};
          end
          step <= step - 1'b1;
          if (step == '0) begin
            state <= (state == S_DIV_AVG) ? S_SIGN : S_FINISH;
          end
        end
        S_SIGN: begin
          avg <= avg_next;
          if (window_kind == KIND_TARE) begin
            tare_offset <= avg_next;
            state       <= S_FINISH;
          end else begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          quo   <= {{(DW-PROD_W){1'b0}}, prod};
          rem   <= '0;
          dvs   <= cal_eff;
          step  <= STEP_W'(DW - 1);
          state <= S_DIV_G;
        end
        S_FINISH: begin
          if (out_free) begin
            rsp_valid   <= 1'b1;
            rsp.kind    <= window_kind;
            rsp.avg_raw <= avg;
            rsp.no_valid <= none;
            if (window_kind == KIND_TARE) begin
              rsp.weight_grams   <= '0;
              rsp.target_reached <= 1'b0;
            end else begin
              rsp.weight_grams   <= grams;
              rsp.target_reached <= (grams >= target_g);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ dv/load_cell_weigher_core_tb.sv @@
// Self-checking testbench for load_cell_weigher_core: directed table, then randomised
// measurement/tare bursts across register settings, checked against a local weighing model.
// Depends on lcw_pkg and load_cell_weigher_core only.
module load_cell_weigher_core_tb
  import lcw_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TOTAL_REQUESTS = 1850;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES  = 100;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req       = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [4:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // expectation typed into the directed table, travelling with the request
  bit   row_typed = 1'b0;
  rsp_t row_rsp   = '0;

  // weighing model: registers and window state
  logic [5:0]  cfg_mwin   = MEASURE_WINDOW_RST;
  logic [5:0]  cfg_twin   = TARE_WINDOW_RST;
  logic [2:0]  cfg_settle = TARE_SETTLE_RST;
  logic [15:0] cfg_cal    = CAL_FACTOR_RST;
  logic [5:0]  cfg_target = TARGET_KG_RST;
  longint      win_sum    = 0;
  int unsigned win_valid  = 0;
  int unsigned win_count  = 0;
  int unsigned settle_cnt = 0;
  logic        win_kind   = KIND_WEIGHT;
  longint      tare_ofs   = 0;

  rsp_t        awaited_readings[$];
  bit          calm = 1'b0;
  int unsigned errors = 0, n_sent = 0, n_weight = 0, n_tare = 0, n_cfg = 0;
  int unsigned quiet_cycles = 0;

  load_cell_weigher_core u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 6);
  endfunction

  function automatic int unsigned window_span(logic [5:0] r);
    if (r == 0) return 1;
    if (r > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
    return r;
  endfunction

  function automatic longint cal_divisor();
    return (cfg_cal == 0) ? 1 : longint'(cfg_cal);
  endfunction

  function automatic void open_window(logic kind);
    win_kind   = kind;
    win_sum    = 0;
    win_valid  = 0;
    win_count  = 0;
    settle_cnt = (kind == KIND_TARE) ? cfg_settle : 0;
  endfunction

  function automatic bit weigh_request(input req_t r, output rsp_t res);
    longint avg, net, grams;
    res = '0;
    if (r.req_type != win_kind) open_window(r.req_type);
    if (settle_cnt != 0) begin
      settle_cnt--;
      return 1'b0;
    end
    win_count++;
    if (!r.timed_out && r.sample != SAT_CODE) begin
      win_sum += longint'($signed(r.sample));
      win_valid++;
    end
    if (win_count < window_span((win_kind == KIND_TARE) ? cfg_twin : cfg_mwin)) return 1'b0;
    avg = (win_valid == 0) ? 0 : win_sum / longint'(win_valid);
    grams = 0;
    res.kind     = win_kind;
    res.avg_raw  = avg[23:0];
    res.no_valid = (win_valid == 0);
    if (win_kind == KIND_TARE) begin
      tare_ofs = avg;
    end else begin
      net = avg - tare_ofs;
      if (net < 0) net = 0;
      grams = net * 1000 / cal_divisor();
      if (grams > 60000) grams = 60000;
      res.weight_grams   = grams[15:0];
      res.target_reached = (grams >= longint'(cfg_target) * 1000);
    end
    open_window(win_kind);
    return 1'b1;
  endfunction

  function automatic void check_result(rsp_t got);
    rsp_t want;
    if (awaited_readings.size() == 0) begin
      $error("unexpected result: kind %0d avg_raw %0d", got.kind, got.avg_raw);
      errors++;
      return;
    end
    want = awaited_readings.pop_front();
    if (want.kind == KIND_TARE) n_tare++;
    else n_weight++;
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      errors++;
    end
    if (got.avg_raw !== want.avg_raw) begin
      $error("avg_raw: expected %0d, got %0d", want.avg_raw, got.avg_raw);
      errors++;
    end
    if (got.weight_grams !== want.weight_grams) begin
      $error("weight_grams: expected %0d, got %0d", want.weight_grams, got.weight_grams);
      errors++;
    end
    if (got.target_reached !== want.target_reached) begin
      $error("target_reached: expected %0d, got %0d", want.target_reached,
             got.target_reached);
      errors++;
    end
    if (got.no_valid !== want.no_valid) begin
      $error("no_valid: expected %0d, got %0d", want.no_valid, got.no_valid);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    rsp_t predicted;
    bit   fires;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        fires = weigh_request(req, predicted);
        if (fires) awaited_readings.push_back(row_typed ? row_rsp : predicted);
      end
      if (rsp_valid && !rsp_stall) check_result(rsp);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  always @(posedge clk) rsp_stall <= !rst && idle_now();

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MEASURE_WINDOW: cfg_mwin   = val[5:0];
      REG_TARE_WINDOW:    cfg_twin   = val[5:0];
      REG_TARE_SETTLE:    cfg_settle = val[2:0];
      REG_CAL_FACTOR:     cfg_cal    = val[15:0];
      REG_TARGET_KG:      cfg_target = val[5:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [5:0] mwin, logic [5:0] twin, logic [2:0] settle,
                            logic [15:0] cal, logic [5:0] target);
    write_reg(REG_MEASURE_WINDOW, {26'd0, mwin});
    write_reg(REG_TARE_WINDOW, {26'd0, twin});
    write_reg(REG_TARE_SETTLE, {29'd0, settle});
    write_reg(REG_CAL_FACTOR, {16'd0, cal});
    write_reg(REG_TARGET_KG, {26'd0, target});
    n_cfg++;
  endtask

  task automatic send_req(req_t r, bit typed, rsp_t want);
    while (idle_now()) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    row_typed <= typed;
    row_rsp   <= want;
    do @(posedge clk); while (req_stall);
    n_sent++;
  endtask

  // wait for every result, then let the divider run out before touching registers
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (awaited_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic req_t make_req(logic kind, longint level);
    req_t        r;
    int unsigned pick;
    longint      v;
    pick = $urandom_range(99);
    v = level + longint'($urandom_range(400)) - 200;
    if (v > 8388607) v = 8388607;
    if (v < -8388607) v = -8388607;
    r.req_type  = kind;
    r.sample    = v[23:0];
    r.timed_out = ($urandom_range(99) < 5);
    if (pick < 8) r.sample = SAMPLE_W'($urandom_range(24'hFFFFFF));
    else if (pick < 12) r.sample = SAT_CODE;
    else if (pick < 14) r.sample = 24'h7FFFFF;
    else if (pick < 16) r.sample = 24'h800001;
    return r;
  endfunction

  // bursts of one request type, mostly sized to complete windows, some cut short
  task automatic run_phase(int unsigned n_items);
    int unsigned done_n, blen, i;
    logic        kind;
    longint      level;
    done_n = 0;
    while (done_n < n_items) begin
      kind = ($urandom_range(99) < 25) ? KIND_TARE : KIND_WEIGHT;
      if (kind == KIND_TARE) begin
        blen  = cfg_settle + window_span(cfg_twin);
        level = longint'($urandom_range(600000)) - 300000;
      end else begin
        blen  = window_span(cfg_mwin) * $urandom_range(4, 1);
        level = tare_ofs + longint'($urandom_range(70000)) * cal_divisor() / 1000;
        if ($urandom_range(9) == 0) level = tare_ofs - longint'($urandom_range(5000));
      end
      if ($urandom_range(9) == 0) blen = $urandom_range(blen, 1);
      for (i = 0; i < blen && done_n < n_items; i++) begin
        send_req(make_req(kind, level), 1'b0, '0);
        done_n++;
      end
    end
  endtask

  function automatic dir_row_t row(logic kind, int smp, bit tout, bit typed = 1'b0,
                                   rsp_t want = '0);
    dir_row_t d;
    d.r.req_type  = kind;
    d.r.sample    = smp[23:0];
    d.r.timed_out = tout;
    d.typed       = typed;
    d.want        = want;
    return d;
  endfunction

  initial begin : stimulus
    dir_row_t    rows[$];
    int unsigned ph, chunk;
    // windows: measure 1, tare 2 after one settling request; 1 kg target
    rows.push_back(row(KIND_WEIGHT, 8388607, 1'b0, 1'b1,
                       rsp_t'{KIND_WEIGHT, 24'sd8388607, 16'd60000, 1'b1, 1'b0}));
    rows.push_back(row(KIND_WEIGHT, -8388608, 1'b0, 1'b1,
                       rsp_t'{KIND_WEIGHT, 24'sd0, 16'd0, 1'b0, 1'b1}));
    rows.push_back(row(KIND_WEIGHT, 5, 1'b1, 1'b1,
                       rsp_t'{KIND_WEIGHT, 24'sd0, 16'd0, 1'b0, 1'b1}));
    rows.push_back(row(KIND_WEIGHT, -1000, 1'b0, 1'b1,
                       rsp_t'{KIND_WEIGHT, -24'sd1000, 16'd0, 1'b0, 1'b0}));
    rows.push_back(row(KIND_WEIGHT, 1000, 1'b0, 1'b1,
                       rsp_t'{KIND_WEIGHT, 24'sd1000, 16'd1000, 1'b1, 1'b0}));
    rows.push_back(row(KIND_WEIGHT, 999, 1'b0, 1'b1,
                       rsp_t'{KIND_WEIGHT, 24'sd999, 16'd999, 1'b0, 1'b0}));
    rows.push_back(row(KIND_TARE, 100, 1'b0));
    rows.push_back(row(KIND_TARE, 300, 1'b0));
    rows.push_back(row(KIND_TARE, 501, 1'b0));
    rows.push_back(row(KIND_TARE, -8388608, 1'b0));
    rows.push_back(row(KIND_TARE, -7, 1'b0));
    rows.push_back(row(KIND_TARE, -8, 1'b0));
    rows.push_back(row(KIND_TARE, -8388608, 1'b0));
    rows.push_back(row(KIND_TARE, 12345, 1'b1));
    rows.push_back(row(KIND_TARE, -8388608, 1'b0, 1'b1,
                       rsp_t'{KIND_TARE, 24'sd0, 16'd0, 1'b0, 1'b1}));
    rows.push_back(row(KIND_TARE, 77, 1'b0));
    rows.push_back(row(KIND_TARE, 40, 1'b0));
    rows.push_back(row(KIND_WEIGHT, 1400, 1'b0, 1'b1,
                       rsp_t'{KIND_WEIGHT, 24'sd1400, 16'd1400, 1'b1, 1'b0}));
    rows.push_back(row(KIND_TARE, 111, 1'b0));
    rows.push_back(row(KIND_TARE, 2000, 1'b0));
    rows.push_back(row(KIND_TARE, 2000, 1'b0));
    rows.push_back(row(KIND_WEIGHT, 1500, 1'b0));
    rows.push_back(row(KIND_WEIGHT, 8388607, 1'b0));
    rows.push_back(row(KIND_WEIGHT, 2001, 1'b0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_config(6'd1, 6'd2, 3'd1, 16'd1000, 6'd1);
    foreach (rows[i]) send_req(rows[i].r, rows[i].typed, rows[i].want);
    drain();

    for (ph = 1; n_sent < TOTAL_REQUESTS; ph++) begin
      case (ph)
        1: set_config(MEASURE_WINDOW_RST, TARE_WINDOW_RST, TARE_SETTLE_RST, CAL_FACTOR_RST,
                      TARGET_KG_RST);
        2: set_config(6'd0, 6'd0, 3'd0, 16'd0, 6'd0);
        3: set_config(6'd63, 6'd63, 3'd7, 16'd65535, 6'd63);
        4: set_config(6'd32, 6'd32, 3'd7, 16'd1, 6'd60);
        5: set_config(6'd2, 6'd3, 3'd1, 16'd1000, 6'd30);
        default: set_config(
                   6'(($urandom_range(9) < 8) ? $urandom_range(8, 1) : $urandom_range(63)),
                   6'(($urandom_range(9) < 8) ? $urandom_range(8, 1) : $urandom_range(63)),
                   3'($urandom_range(7)),
                   16'(($urandom_range(1) != 0) ? $urandom_range(3000, 200)
                                                : $urandom_range(65535)),
                   6'($urandom_range(63)));
      endcase
      chunk = $urandom_range(180, 100);
      if (chunk > TOTAL_REQUESTS - n_sent) chunk = TOTAL_REQUESTS - n_sent;
      calm = (ph == 5);
      run_phase(chunk);
      calm = 1'b0;
      drain();
    end

    $display("tb: %0d requests over %0d register settings", n_sent, n_cfg);
    $display("tb: %0d weight and %0d tare results checked", n_weight, n_tare);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
